// ===== sv/dqb_pkg.sv =====
// ----------------------------------------------------------------------------
// dqb_pkg: shared types, constants and functions of the DNS query encoder
// Byte source codes, controller/datapath command and status bundles,
// header/trailer byte tables and the base64url character map.
// ----------------------------------------------------------------------------
package dqb_pkg;

  localparam int unsigned MaxLabel = 63;   // longest label before a split
  localparam int unsigned LenW     = 6;    // label length and step counter
  localparam int unsigned CharW    = 7;    // one base64url ASCII character
  localparam int unsigned CountW   = 3;    // characters in a group

  localparam logic [7:0]        DotChar     = 8'h2E;
  localparam logic [LenW-1:0]   HdrLastStep = 6'd11;  // 12 header bytes
  localparam logic [LenW-1:0]   TrlLastStep = 6'd4;   // root, QTYPE, QCLASS
  localparam logic [CountW-1:0] CountFull   = 3'd4;

  typedef enum logic [1:0] {
    SRC_HDR,
    SRC_LEN,
    SRC_MEM,
    SRC_TRL
  } byte_src_e;

  typedef struct packed {
    logic      accept;    // latch the incoming character
    logic      push;      // append one byte to the stream
    byte_src_e src;       // where the pushed byte comes from
    logic      step_clr;
    logic      step_inc;
    logic      store;     // write the character into the label buffer
    logic      len_clr;   // label flushed
    logic      partial;   // emit the short final group and drop the carry
    logic      hand_off;  // hand the held group to the output, closing the run
  } dqb_cmd_t;

  typedef struct packed {
    logic [LenW-1:0] step;
    logic [LenW-1:0] lbl_len;
    logic            is_dot;
    logic            last;
    logic            carry_nz;
    logic            push_ok;
    logic            group_ok;
    logic            out_free;
    logic            pend_valid;
  } dqb_status_t;

  function automatic logic [CharW-1:0] b64_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'd26) begin
      c = 8'd65 + {2'b00, idx};
    end else if (idx < 6'd52) begin
      c = 8'd71 + {2'b00, idx};
    end else if (idx < 6'd62) begin
      c = {2'b00, idx} - 8'd4;
    end else if (idx == 6'd62) begin
      c = 8'd45;
    end else begin
      c = 8'd95;
    end
    return c[CharW-1:0];
  endfunction

  // Header: id, flags 0x0100, QDCOUNT 1, other counts zero
  function automatic logic [7:0] hdr_byte(input logic [LenW-1:0] step,
                                          input logic [15:0] id);
    logic [7:0] b;
    case (step)
      6'd0:    b = id[15:8];
      6'd1:    b = id[7:0];
      6'd2:    b = 8'h01;
      6'd5:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Trailer: root label, QTYPE, QCLASS 1
  function automatic logic [7:0] trl_byte(input logic [LenW-1:0] step,
                                          input logic [15:0] qtype);
    logic [7:0] b;
    case (step)
      6'd1:    b = qtype[15:8];
      6'd2:    b = qtype[7:0];
      6'd4:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/dqb_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqb_ctrl: query sequencer
// Walks one character through header, label flush, store and trailer phases,
// issuing one byte push per cycle when the datapath can take it.
// ----------------------------------------------------------------------------
module dqb_ctrl
  import dqb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_first_i,
  output logic        in_ready_o,
  input  dqb_status_t status_i,
  output dqb_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_PRE,
    ST_LEN,
    ST_DATA,
    ST_STORE,
    ST_POST,
    ST_TRL,
    ST_PART,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   handled_q, handled_d;   // character stored or consumed as a dot
  state_e after_flush;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    if (!handled_q) begin
      after_flush = ST_STORE;
    end else if (status_i.last) begin
      after_flush = ST_TRL;
    end else begin
      after_flush = ST_DONE;
    end
  end

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    handled_d = handled_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept   = 1'b1;
          cmd_o.step_clr = 1'b1;
          handled_d      = 1'b0;
          state_d        = in_first_i ? ST_HDR : ST_PRE;
        end
      end
      ST_HDR: begin
        cmd_o.src = SRC_HDR;
        if (status_i.push_ok) begin
          cmd_o.push = 1'b1;
          if (status_i.step == HdrLastStep) begin
            cmd_o.step_clr = 1'b1;
            state_d        = ST_PRE;
          end else begin
            cmd_o.step_inc = 1'b1;
          end
        end
      end
      ST_PRE: begin
        if (status_i.is_dot) begin
          handled_d = 1'b1;
          state_d   = ST_LEN;
        end else if (status_i.lbl_len == LenW'(MaxLabel)) begin
          state_d = ST_LEN;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_LEN: begin
        cmd_o.src = SRC_LEN;
        if (status_i.push_ok) begin
          cmd_o.push     = 1'b1;
          cmd_o.step_clr = 1'b1;
          if (status_i.lbl_len == '0) begin
            cmd_o.len_clr = 1'b1;
            state_d       = after_flush;
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        cmd_o.src = SRC_MEM;
        if (status_i.push_ok) begin
          cmd_o.push = 1'b1;
          if (status_i.step == status_i.lbl_len - 6'd1) begin
            cmd_o.step_clr = 1'b1;
            cmd_o.len_clr  = 1'b1;
            state_d        = after_flush;
          end else begin
            cmd_o.step_inc = 1'b1;
          end
        end
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        handled_d   = 1'b1;
        state_d     = ST_POST;
      end
      ST_POST: begin
        state_d = status_i.last ? ST_LEN : ST_DONE;
      end
      ST_TRL: begin
        cmd_o.src = SRC_TRL;
        if (status_i.push_ok) begin
          cmd_o.push = 1'b1;
          if (status_i.step == TrlLastStep) begin
            cmd_o.step_clr = 1'b1;
            state_d        = ST_PART;
          end else begin
            cmd_o.step_inc = 1'b1;
          end
        end
      end
      ST_PART: begin
        if (!status_i.carry_nz || status_i.group_ok) begin
          cmd_o.partial = 1'b1;
          state_d       = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.hand_off = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      handled_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      handled_q <= handled_d;
    end
  end

endmodule

// ===== sv/dqb_datapath.sv =====
// ----------------------------------------------------------------------------
// dqb_datapath: label buffer, byte packer and output stage
// Holds the current label in a small memory, packs pushed bytes into 3-byte
// groups, holds the newest group until its run flags are known, then encodes
// it into base64url characters in the output register.
// ----------------------------------------------------------------------------
module dqb_datapath
  import dqb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dqb_cmd_t          cmd_i,
  output dqb_status_t       status_o,
  input  logic [7:0]        ch_i,
  input  logic              first_i,
  input  logic              last_i,
  input  logic [15:0]       id_i,
  input  logic [15:0]       qtype_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [CharW-1:0]  out_char0_o,
  output logic [CharW-1:0]  out_char1_o,
  output logic [CharW-1:0]  out_char2_o,
  output logic [CharW-1:0]  out_char3_o,
  output logic [CountW-1:0] out_count_o,
  output logic              out_last_o,
  output logic              out_end_o
);

  // Current item
  logic [7:0]  ch_q;
  logic        last_q;
  logic [15:0] id_q;
  logic [15:0] qtype_q;

  // Label buffer
  logic [7:0]      label_mem [MaxLabel];
  logic [7:0]      rd_q;
  logic [LenW-1:0] lbl_len_q;
  logic [LenW-1:0] step_q, step_d;

  // Byte packer
  logic [7:0] carry0_q, carry1_q;
  logic [1:0] carry_cnt_q;

  // Group waiting for its run flags
  logic              pend_valid_q;
  logic [7:0]        pend_b0_q, pend_b1_q, pend_b2_q;
  logic [CountW-1:0] pend_cnt_q;

  // Output register
  logic              out_valid_q;
  logic [CharW-1:0]  out_c0_q, out_c1_q, out_c2_q, out_c3_q;
  logic [CountW-1:0] out_cnt_q;
  logic              out_last_q, out_end_q;

  logic [7:0]        byte_val;
  logic              group_form, out_load, out_free, group_ok;
  logic [7:0]        g1, g2;
  logic [CountW-1:0] gcnt;
  logic [23:0]       pend_word;

  always_comb begin
    case (cmd_i.src)
      SRC_HDR: byte_val = hdr_byte(step_q, id_q);
      SRC_LEN: byte_val = {2'b00, lbl_len_q};
      SRC_MEM: byte_val = rd_q;
      SRC_TRL: byte_val = trl_byte(step_q, qtype_q);
      default: byte_val = 8'h00;
    endcase
  end

  always_comb begin
    if (cmd_i.step_clr) begin
      step_d = '0;
    end else if (cmd_i.step_inc) begin
      step_d = step_q + 6'd1;
    end else begin
      step_d = step_q;
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign group_ok   = !pend_valid_q || out_free;
  assign group_form = (cmd_i.push && carry_cnt_q == 2'd2) ||
                      (cmd_i.partial && carry_cnt_q != 2'd0);
  assign out_load   = (group_form && pend_valid_q) || cmd_i.hand_off;
  assign g1         = (carry_cnt_q == 2'd2) ? carry1_q : 8'h00;
  assign g2         = cmd_i.push ? byte_val : 8'h00;
  assign gcnt       = cmd_i.push ? CountFull : ({1'b0, carry_cnt_q} + 3'd1);
  assign pend_word  = {pend_b0_q, pend_b1_q, pend_b2_q};

  assign status_o.step       = step_q;
  assign status_o.lbl_len    = lbl_len_q;
  assign status_o.is_dot     = (ch_q == DotChar);
  assign status_o.last       = last_q;
  assign status_o.carry_nz   = (carry_cnt_q != 2'd0);
  assign status_o.push_ok    = (carry_cnt_q != 2'd2) || group_ok;
  assign status_o.group_ok   = group_ok;
  assign status_o.out_free   = out_free;
  assign status_o.pend_valid = pend_valid_q;

  // Label memory: write on store, read always at the next step
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      label_mem[lbl_len_q] <= ch_q;
    end
    rd_q <= label_mem[step_d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ch_q <= ch_i;
      id_q <= id_i;
    end
    if (group_form) begin
      pend_b0_q  <= carry0_q;
      pend_b1_q  <= g1;
      pend_b2_q  <= g2;
      pend_cnt_q <= gcnt;
    end
    if (cmd_i.push && carry_cnt_q != 2'd2) begin
      if (carry_cnt_q[0]) begin
        carry1_q <= byte_val;
      end else begin
        carry0_q <= byte_val;
      end
    end
    if (out_load) begin
      out_c0_q  <= b64_char(pend_word[23:18]);
      out_c1_q  <= b64_char(pend_word[17:12]);
      out_c2_q  <= (pend_cnt_q >= 3'd3) ? b64_char(pend_word[11:6]) : '0;
      out_c3_q  <= (pend_cnt_q == CountFull) ? b64_char(pend_word[5:0]) : '0;
      out_cnt_q <= pend_cnt_q;
      out_last_q <= cmd_i.hand_off;
      out_end_q  <= cmd_i.hand_off && last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q       <= 1'b0;
      qtype_q      <= '0;
      lbl_len_q    <= '0;
      step_q       <= '0;
      carry_cnt_q  <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      step_q <= step_d;
      if (cmd_i.accept) begin
        last_q <= last_i;
        if (first_i) begin
          qtype_q     <= qtype_i;
          lbl_len_q   <= '0;
          carry_cnt_q <= '0;
        end
      end
      if (cmd_i.store) begin
        lbl_len_q <= lbl_len_q + 6'd1;
      end else if (cmd_i.len_clr) begin
        lbl_len_q <= '0;
      end
      if (cmd_i.partial) begin
        carry_cnt_q <= '0;
      end else if (cmd_i.push) begin
        carry_cnt_q <= (carry_cnt_q == 2'd2) ? 2'd0 : carry_cnt_q + 2'd1;
      end
      if (group_form) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.hand_off) begin
        pend_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char0_o = out_c0_q;
  assign out_char1_o = out_c1_q;
  assign out_char2_o = out_c2_q;
  assign out_char3_o = out_c3_q;
  assign out_count_o = out_cnt_q;
  assign out_last_o  = out_last_q;
  assign out_end_o   = out_end_q;

endmodule

// ===== sv/dns_query_base64url_encoder_top.sv =====
// ----------------------------------------------------------------------------
// dns_query_base64url_encoder_top: hostname to base64url DNS wire query
// Builds a DNS query (header, length-prefixed labels, root, QTYPE, QCLASS)
// from a stream of hostname characters and emits it base64url-encoded,
// without padding, one group of up to four characters per transaction.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | tdata (low bit first)                  | tuser      | tlast
//  ---------+-----------+----------------------------------------+------------+------------
//  s_axis   | in        | name_char[7:0] query_id[15:0]          | first_char | last_char
//           |           | query_type[15:0]  (40 bits)            |            |
//  m_axis   | out       | out_char0..3 [6:0] each, char_count    | query_end  | last_of_run
//           |           | [2:0], one zero pad bit  (32 bits)     |            |
//
//  Sequencing: a character is accepted and checked; a dot, or a character
//  arriving at a full label, flushes the label; a non-dot character is then
//  stored, and a final character flushes its label and adds the trailer.
//  Bytes added: 12 for a header, label length + 1 per label flush, 5 for the
//  trailer. At most one byte is pushed per cycle; the single push port sets the rate.
//  Stalls: a full group waits in a holding stage until the next group or the
//  end of the item settles its tlast; the sequencer pauses while both the
//  holding stage and the output register are occupied and m_axis is stalled.
//  Reset: asynchronous, active low; clears sequencer state, label length,
//  carried byte count and held QTYPE. The label buffer needs no clearing.
// ----------------------------------------------------------------------------
module dns_query_base64url_encoder_top
  import dqb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input characters
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // name_char[7:0], query_id[23:8], query_type[39:24]
  input  logic        s_axis_tuser,   // first_char
  input  logic        s_axis_tlast,   // last_char
  // Encoded groups
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_char0[6:0], out_char1[13:7], out_char2[20:14],
                                      // out_char3[27:21], char_count[30:28], zero[31]
  output logic        m_axis_tuser,   // query_end
  output logic        m_axis_tlast    // last_of_run
);

  dqb_cmd_t    cmd;
  dqb_status_t status;

  logic [CharW-1:0]  char0, char1, char2, char3;
  logic [CountW-1:0] count;

  // Sequence header, label flushes and trailer for each accepted character
  dqb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_first_i (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Buffer labels, pack bytes into groups and encode them
  dqb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .ch_i        (s_axis_tdata[7:0]),
    .first_i     (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .id_i        (s_axis_tdata[23:8]),
    .qtype_i     (s_axis_tdata[39:24]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char0_o (char0),
    .out_char1_o (char1),
    .out_char2_o (char2),
    .out_char3_o (char3),
    .out_count_o (count),
    .out_last_o  (m_axis_tlast),
    .out_end_o   (m_axis_tuser)
  );

  // Pack the group fields, lowest field first, pad to whole bytes
  assign m_axis_tdata = {1'b0, count, char3, char2, char1, char0};

endmodule
